// ----- hdl/ohash_pkg.sv -----
// Shared types, codes and a helper function for the open-addressing hash table.
package ohash_pkg;

    // Slot numbers and the table size fit in seven bits.
    localparam int SW = 7;
    localparam int KEYW = 13;
    localparam int DEPTHW = 24;
    localparam int NAMEW = 32;
    localparam int WORDW = KEYW + DEPTHW + NAMEW;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    localparam logic [SW-1:0] SIZE_MIN = 7'd2;

    typedef enum logic [1:0] {
        A_SCAN  = 2'd0,
        A_PROBE = 2'd1,
        A_IDX   = 2'd2
    } addr_sel_t;

    typedef enum logic [2:0] {
        R_EMPTY    = 3'd0,
        R_EMPTY_AT = 3'd1,
        R_MEM      = 3'd2,
        R_NEW      = 3'd3,
        R_READ     = 3'd4
    } res_kind_t;

    typedef struct packed {
        logic      latch;
        logic      reduce;
        logic      pinit;
        logic      addr_ld;
        addr_sel_t addr_sel;
        logic      adv;
        logic      wr;
        logic      res_load;
        res_kind_t res_kind;
        logic [2:0] res_status;
    } ohash_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_oor;
        logic       reduced;
        logic       last;
        logic       hit;
        logic       free;
        logic       out_busy;
    } ohash_stat_t;

    // Remainder by seven of a six-bit value, through a reciprocal multiply.
    function automatic logic [2:0] mod7(input logic [5:0] k);
        logic [11:0] prod;
        logic [5:0]  q;
        logic [5:0]  r;
        prod = {6'd0, k} * 12'd37;
        q = prod[11:8] == 4'd0 ? 6'd0 : {2'd0, prod[11:8]};
        r = k - 6'(q * 6'd7);
        return r[2:0];
    endfunction

endpackage

// ----- hdl/ohash_ctrl.sv -----
// Controller state machine that sequences scans, probes and reads.
module ohash_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ohash_pkg::ohash_stat_t st,
    output ohash_pkg::ohash_cmd_t  cmd
);
    import ohash_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_HOME     = 8'b0000_0100,
        S_SCAN_RD  = 8'b0000_1000,
        S_SCAN_CK  = 8'b0001_0000,
        S_PROBE_RD = 8'b0010_0000,
        S_PROBE_CK = 8'b0100_0000,
        S_READ_CK  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.addr_sel = A_SCAN;
        cmd.res_kind = R_EMPTY;
        cmd.res_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.op == OP_INSERT || st.op == OP_SEARCH)
                begin
                    state_next = S_HOME;
                end
                else if (st.op == OP_READ && !st.idx_oor)
                begin
                    cmd.addr_ld = 1'b1;
                    cmd.addr_sel = A_IDX;
                    state_next = S_READ_CK;
                end
                else if (!st.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_status = ST_RANGE;
                    cmd.res_kind = (st.op == OP_READ) ? R_EMPTY_AT : R_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_HOME:
            begin
                if (st.reduced)
                begin
                    cmd.pinit = 1'b1;
                    state_next = (st.op == OP_INSERT) ? S_SCAN_RD : S_PROBE_RD;
                end
                else
                begin
                    cmd.reduce = 1'b1;
                end
            end
            S_SCAN_RD:
            begin
                cmd.addr_ld = 1'b1;
                cmd.addr_sel = A_SCAN;
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                if (st.hit)
                begin
                    if (!st.out_busy)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_status = ST_DUPLICATE;
                        cmd.res_kind = R_MEM;
                        state_next = S_IDLE;
                    end
                end
                else if (st.last)
                begin
                    cmd.pinit = 1'b1;
                    state_next = S_PROBE_RD;
                end
                else
                begin
                    cmd.adv = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_PROBE_RD:
            begin
                cmd.addr_ld = 1'b1;
                cmd.addr_sel = A_PROBE;
                state_next = S_PROBE_CK;
            end
            S_PROBE_CK:
            begin
                if (st.op == OP_INSERT)
                begin
                    if (st.free || st.last)
                    begin
                        if (!st.out_busy)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.wr = st.free;
                            cmd.res_status = st.free ? ST_OK : ST_FULL;
                            cmd.res_kind = st.free ? R_NEW : R_EMPTY;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.adv = 1'b1;
                        state_next = S_PROBE_RD;
                    end
                end
                else
                begin
                    if (st.hit || st.last)
                    begin
                        if (!st.out_busy)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_status = st.hit ? ST_OK : ST_NOT_FOUND;
                            cmd.res_kind = st.hit ? R_MEM : R_EMPTY;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.adv = 1'b1;
                        state_next = S_PROBE_RD;
                    end
                end
            end
            S_READ_CK:
            begin
                if (!st.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_kind = R_READ;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/ohash_dp.sv -----
// Datapath: slot memory, valid bits, probe arithmetic and result register.
module ohash_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ohash_pkg::ohash_cmd_t cmd,
    output ohash_pkg::ohash_stat_t st,
    input  logic [6:0]            table_size,
    input  logic                  probe_mode,
    input  logic [1:0]            opcode,
    input  logic [4:0]            id_letter,
    input  logic [3:0]            id_tens,
    input  logic [3:0]            id_units,
    input  logic [23:0]           dept_code,
    input  logic [31:0]           name_handle,
    input  logic [5:0]            slot_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    output logic                  slot_used,
    output logic [5:0]            found_slot,
    output logic [4:0]            out_letter,
    output logic [3:0]            out_tens,
    output logic [3:0]            out_units,
    output logic [23:0]           out_dept,
    output logic [31:0]           out_name,
    output logic [6:0]            occupancy
);
    import ohash_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [WORDW-1:0] mem [TABLE_DEPTH];
    logic [WORDW-1:0] rdata_reg;
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [6:0] cnt_reg, cnt_next;
    logic out_valid_reg;

    logic [1:0]  op_reg;
    logic [4:0]  let_reg;
    logic [3:0]  ten_reg;
    logic [3:0]  uni_reg;
    logic [23:0] dept_reg;
    logic [31:0] name_reg;
    logic [5:0]  idx_reg;
    logic [SW-1:0] n_reg;
    logic        mode_reg;

    logic [SW-1:0] acc_reg, stp_reg, off_reg, inc_reg, i_reg, addr_reg;
    logic [SW-1:0] n_eff, pos, addr_mux, off_next, inc_next;
    logic [SW:0]   pos_sum, off_sum, inc_sum;
    logic [5:0]    keyval;
    logic [KEYW-1:0] packed_key;
    logic          vld_at;

    logic [2:0]  res_status_reg;
    logic        res_used_reg;
    logic [5:0]  res_slot_reg;
    logic [KEYW-1:0] res_key_reg;
    logic [23:0] res_dept_reg;
    logic [31:0] res_name_reg;
    logic [6:0]  res_occ_reg;

    always_comb
    begin
        n_eff = table_size;
        if (table_size < SIZE_MIN)
        begin
            n_eff = SIZE_MIN;
        end
        else if (32'(table_size) > 32'(TABLE_DEPTH))
        begin
            n_eff = SW'(TABLE_DEPTH);
        end
    end

    assign keyval = {1'b0, id_letter} + {2'b00, id_tens} + {2'b00, id_units};
    assign packed_key = {let_reg, ten_reg, uni_reg};

    // Probe position: home slot plus the running offset, both below n.
    assign pos_sum = {1'b0, acc_reg} + {1'b0, off_reg};
    assign pos = (pos_sum >= {1'b0, n_reg}) ? SW'(pos_sum - {1'b0, n_reg}) : pos_sum[SW-1:0];

    assign off_sum = {1'b0, off_reg} + {1'b0, (mode_reg ? inc_reg : stp_reg)};
    assign off_next = (off_sum >= {1'b0, n_reg}) ? SW'(off_sum - {1'b0, n_reg})
                                                 : off_sum[SW-1:0];
    assign inc_sum = {1'b0, inc_reg} + 8'd2;
    assign inc_next = (inc_sum >= {1'b0, n_reg}) ? SW'(inc_sum - {1'b0, n_reg})
                                                 : inc_sum[SW-1:0];

    always_comb
    begin
        case (cmd.addr_sel)
            A_SCAN:  addr_mux = i_reg;
            A_PROBE: addr_mux = pos;
            A_IDX:   addr_mux = {1'b0, idx_reg};
            default: addr_mux = i_reg;
        endcase
    end

    assign vld_at = vld_reg[AW'(addr_reg)];

    assign st.op       = op_reg;
    assign st.idx_oor  = ({1'b0, idx_reg} >= n_reg);
    assign st.reduced  = (acc_reg < n_reg) && (stp_reg < n_reg);
    assign st.last     = (i_reg == n_reg - 7'd1);
    assign st.hit      = vld_at && (rdata_reg[WORDW-1 -: KEYW] == packed_key);
    assign st.free     = !vld_at;
    assign st.out_busy = out_valid_reg;

    assign cnt_next = (cmd.wr && cnt_reg != 7'd127) ? cnt_reg + 7'd1 : cnt_reg;

    // Latched item fields and probe sequencing registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= opcode;
            let_reg  <= id_letter;
            ten_reg  <= id_tens;
            uni_reg  <= id_units;
            dept_reg <= dept_code;
            name_reg <= name_handle;
            idx_reg  <= slot_index;
            n_reg    <= n_eff;
            mode_reg <= probe_mode;
            acc_reg  <= {keyval, 1'b0};
            stp_reg  <= 7'd7 - {4'd0, mod7(keyval)};
        end
        else if (cmd.reduce)
        begin
            if (acc_reg >= n_reg)
            begin
                acc_reg <= acc_reg - n_reg;
            end
            if (stp_reg >= n_reg)
            begin
                stp_reg <= stp_reg - n_reg;
            end
        end
        if (cmd.pinit)
        begin
            i_reg   <= '0;
            off_reg <= '0;
            inc_reg <= 7'd1;
        end
        else if (cmd.adv)
        begin
            i_reg   <= i_reg + 7'd1;
            off_reg <= off_next;
            if (mode_reg)
            begin
                inc_reg <= inc_next;
            end
        end
        if (cmd.addr_ld)
        begin
            addr_reg <= addr_mux;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[AW'(addr_reg)] <= {packed_key, dept_reg, name_reg};
        end
        if (cmd.addr_ld)
        begin
            rdata_reg <= mem[AW'(addr_mux)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                vld_reg[AW'(addr_reg)] <= 1'b1;
            end
            cnt_reg <= cnt_next;
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_occ_reg <= cnt_next;
            res_used_reg <= 1'b0;
            res_slot_reg <= '0;
            res_key_reg <= '0;
            res_dept_reg <= '0;
            res_name_reg <= '0;
            case (cmd.res_kind)
                R_EMPTY_AT:
                begin
                    res_slot_reg <= idx_reg;
                end
                R_MEM:
                begin
                    res_used_reg <= 1'b1;
                    res_slot_reg <= addr_reg[5:0];
                    {res_key_reg, res_dept_reg, res_name_reg} <= rdata_reg;
                end
                R_NEW:
                begin
                    res_used_reg <= 1'b1;
                    res_slot_reg <= addr_reg[5:0];
                    res_key_reg <= packed_key;
                    res_dept_reg <= dept_reg;
                    res_name_reg <= name_reg;
                end
                R_READ:
                begin
                    res_used_reg <= vld_at;
                    res_slot_reg <= addr_reg[5:0];
                    if (vld_at)
                    begin
                        {res_key_reg, res_dept_reg, res_name_reg} <= rdata_reg;
                    end
                end
                default:
                begin
                    res_used_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = res_status_reg;
    assign slot_used  = res_used_reg;
    assign found_slot = res_slot_reg;
    assign out_letter = res_key_reg[12:8];
    assign out_tens   = res_key_reg[7:4];
    assign out_units  = res_key_reg[3:0];
    assign out_dept   = res_dept_reg;
    assign out_name   = res_name_reg;
    assign occupancy  = res_occ_reg;

endmodule

// ----- hdl/open_addressing_hash_table_core.sv -----
// Top level of the open-addressing hash table: register port and block wiring.
// Items are handled one at a time. A read visits only the indexed slot.
// Search first reduces 2*key mod n by repeated subtraction, then probes up to n slots.
// Insert does the same reduction, scans up to n slots for a duplicate, then probes.
// Each slot visit is a read state then a check state, as the slot memory read is registered.
// Reset clears the valid bits, the entry count and the registers (size 11).
module open_addressing_hash_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [4:0]  id_letter,
    input  logic [3:0]  id_tens,
    input  logic [3:0]  id_units,
    input  logic [23:0] dept_code,
    input  logic [31:0] name_handle,
    input  logic [5:0]  slot_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        slot_used,
    output logic [5:0]  found_slot,
    output logic [4:0]  out_letter,
    output logic [3:0]  out_tens,
    output logic [3:0]  out_units,
    output logic [23:0] out_dept,
    output logic [31:0] out_name,
    output logic [6:0]  occupancy
);
    import ohash_pkg::*;

    // Register addresses: table_size at 0, probe_mode at 4.
    localparam logic REG_SIZE = 1'b0;
    localparam logic REG_MODE = 1'b1;

    logic [6:0] table_size_reg;
    logic       probe_mode_reg;
    logic       cfg_wr;

    ohash_cmd_t  cmd;
    ohash_stat_t st;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= 7'd11;
            probe_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SIZE)
            begin
                table_size_reg <= pwdata[6:0];
            end
            else
            begin
                probe_mode_reg <= pwdata[0];
            end
        end
    end

    // Reads return the register selected by the word address.
    always_comb
    begin
        case (paddr[2])
            REG_SIZE: prdata = {25'd0, table_size_reg};
            REG_MODE: prdata = {31'd0, probe_mode_reg};
            default:  prdata = '0;
        endcase
    end

    // The controller decides the sequence of slot visits; the datapath holds
    // the table and does the modular probe arithmetic one step per command.
    ohash_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    ohash_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .table_size  (table_size_reg),
        .probe_mode  (probe_mode_reg),
        .opcode      (opcode),
        .id_letter   (id_letter),
        .id_tens     (id_tens),
        .id_units    (id_units),
        .dept_code   (dept_code),
        .name_handle (name_handle),
        .slot_index  (slot_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot_used   (slot_used),
        .found_slot  (found_slot),
        .out_letter  (out_letter),
        .out_tens    (out_tens),
        .out_units   (out_units),
        .out_dept    (out_dept),
        .out_name    (out_name),
        .occupancy   (occupancy)
    );

endmodule
